>>> src/cdr_pkg.sv
package cdr_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_JERK_THRESHOLD  = 3'd0,
    REG_JERK_WINDOW     = 3'd1,
    REG_JERK_NEEDED     = 3'd2,
    REG_CURRENT_WINDOW  = 3'd3,
    REG_CURRENT_NEEDED  = 3'd4,
    REG_SPIKE_RATIO     = 3'd5,
    REG_BUMPER_DEBOUNCE = 3'd6,
    REG_RESUME_DELAY    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_OK       = 3'd0,
    PH_DETECTED = 3'd1,
    PH_STOPPED  = 3'd2,
    PH_RETREAT  = 3'd3,
    PH_TURN     = 3'd4,
    PH_RESUME   = 3'd5
  } phase_t;

  localparam logic [0:0] OP_UPDATE = 1'b0;
  localparam logic [0:0] OP_CLEAR  = 1'b1;

  localparam logic [16:0] AlphaQ16        = 17'd64225;
  localparam logic [10:0] OneMinusAlpha   = 11'd1311;
  localparam logic [31:0] BaselineMinQ16  = 32'd6553600;
  localparam logic [31:0] BaselineResetQ16 = 32'd32768000;
  localparam logic [31:0] StopMs          = 32'd100;
  localparam logic [31:0] RetreatMs       = 32'd300;
  localparam logic [31:0] TurnMs          = 32'd500;

  typedef struct packed {
    logic [0:0]  operation;
    logic [31:0] now_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] motor_current;
    logic [0:0]  bumper_left;
    logic [0:0]  bumper_right;
  } item_t;

  typedef struct packed {
    logic [2:0]  response_state;
    logic [0:0]  active;
    logic [0:0]  jerk_flag;
    logic [0:0]  current_flag;
    logic [0:0]  bumper_flag;
    logic [0:0]  bumper_level;
    logic [17:0] jerk_sum;
    logic [15:0] baseline_ma;
    logic [31:0] collision_count;
    logic [31:0] bumper_event_count;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_t;

  typedef struct packed {
    logic [17:0] jerk_threshold;
    logic [15:0] jerk_window_ms;
    logic [7:0]  jerk_samples_needed;
    logic [15:0] current_window_ms;
    logic [7:0]  current_samples_needed;
    logic [7:0]  spike_ratio_q4;
    logic [15:0] bumper_debounce_ms;
    logic [15:0] resume_delay_ms;
  } cfg_regs_t;

  // Per-item hit report that each lane hands to the merge stage.
  typedef struct packed {
    logic jerk_hit;
    logic current_hit;
    logic bumper_hit;
  } lane_hits_t;

endpackage

>>> src/cdr_if.sv
interface cdr_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/cdr_jerk_lane.sv
module cdr_jerk_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                clear,
  input  cdr_pkg::item_t      item,
  input  cdr_pkg::cfg_regs_t  cfg,
  output logic                hit,
  output logic [17:0]         jerk_value
);
  import cdr_pkg::*;

  logic signed [15:0] last_accel [3];
  logic [7:0]  jerk_counter;
  logic [31:0] jerk_window_begin;
  logic [16:0] d [3];
  logic [17:0] sum;
  logic        expired;
  logic [7:0]  cnt_base;
  logic [7:0]  cnt_inc;
  logic        over;

  function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic signed [16:0] t;
    t = 17'(a) - 17'(b);
    return t[16] ? 17'(-t) : 17'(t);
  endfunction

  always_comb begin
    d[0] = absdiff(item.accel_x, last_accel[0]);
    d[1] = absdiff(item.accel_y, last_accel[1]);
    d[2] = absdiff(item.accel_z, last_accel[2]);
    sum = 18'(d[0]) + 18'(d[1]) + 18'(d[2]);
    expired = (item.now_ms - jerk_window_begin) > 32'(cfg.jerk_window_ms);
    cnt_base = expired ? 8'd0 : jerk_counter;
    over = sum > cfg.jerk_threshold;
    cnt_inc = cnt_base + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accel[0] <= '0;
      last_accel[1] <= '0;
      last_accel[2] <= '0;
      jerk_value <= '0;
      jerk_counter <= '0;
      jerk_window_begin <= '0;
      hit <= 1'b0;
    end else if (clear) begin
      jerk_counter <= '0;
      hit <= 1'b0;
    end else if (start) begin
      last_accel[0] <= item.accel_x;
      last_accel[1] <= item.accel_y;
      last_accel[2] <= item.accel_z;
      jerk_value <= sum;
      if (expired) jerk_window_begin <= item.now_ms;
      jerk_counter <= over ? cnt_inc : cnt_base;
      hit <= over && (cnt_inc >= cfg.jerk_samples_needed);
    end
  end
endmodule

>>> src/cdr_current_lane.sv
module cdr_current_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                clear,
  input  cdr_pkg::item_t      item,
  input  cdr_pkg::cfg_regs_t  cfg,
  output logic                hit,
  output logic                done,
  output logic [15:0]         baseline_ma
);
  import cdr_pkg::*;

  // Steps in order: baseline products, new baseline, ratio product, spike compare.
  logic [31:0] current_average;
  logic [7:0]  spike_counter;
  logic [31:0] spike_window_begin;
  logic [1:0]  step;
  logic [15:0] mag;
  logic [15:0] mag_in;
  logic [48:0] p_avg;
  logic [26:0] p_mag;
  logic [39:0] p_ratio;
  logic [48:0] acc;
  logic [7:0]  cnt_base;
  logic [7:0]  cnt_inc;
  logic        spike;
  logic        expired;

  assign mag_in = item.motor_current[15] ? 16'(-item.motor_current)
                                         : 16'(item.motor_current);
  assign acc = p_avg + {p_mag, 16'd0} + 49'd32768;
  assign expired = (item.now_ms - spike_window_begin) > 32'(cfg.current_window_ms);
  assign cnt_base = expired ? 8'd0 : spike_counter;
  assign cnt_inc = cnt_base + 8'd1;
  assign spike = (current_average > BaselineMinQ16) &&
                 (40'({mag, 20'd0}) > p_ratio);
  assign baseline_ma = current_average[31:16];

  always_ff @(posedge clk) begin
    p_avg <= 49'(current_average) * 49'(AlphaQ16);
    p_mag <= 27'(mag_in) * 27'(OneMinusAlpha);
    p_ratio <= 40'(current_average) * 40'(cfg.spike_ratio_q4);
    if (start) mag <= mag_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_average <= BaselineResetQ16;
      spike_counter <= '0;
      spike_window_begin <= '0;
      step <= '0;
      hit <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (clear) begin
        spike_counter <= '0;
        hit <= 1'b0;
      end else if (start) begin
        step <= 2'd1;
        hit <= 1'b0;
      end else if (step == 2'd1) begin
        current_average <= acc[47:16];
        step <= 2'd2;
      end else if (step == 2'd2) begin
        step <= 2'd3;
      end else if (step == 2'd3) begin
        step <= 2'd0;
        done <= 1'b1;
        if (expired) spike_window_begin <= item.now_ms;
        spike_counter <= spike ? cnt_inc : cnt_base;
        hit <= spike && (cnt_inc >= cfg.current_samples_needed);
      end
    end
  end
endmodule

>>> src/cdr_bumper_lane.sv
module cdr_bumper_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cdr_pkg::item_t      item,
  input  cdr_pkg::cfg_regs_t  cfg,
  output logic                level
);
  import cdr_pkg::*;

  logic        pending;
  logic [31:0] change_time;
  logic [31:0] ref_time;
  logic        pressed;

  assign pressed = item.bumper_left[0] | item.bumper_right[0];
  assign ref_time = pending ? change_time : item.now_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b0;
      pending <= 1'b0;
      change_time <= '0;
    end else if (start) begin
      if (pressed != level) begin
        if (!pending) change_time <= item.now_ms;
        if ((item.now_ms - ref_time) > 32'(cfg.bumper_debounce_ms)) begin
          level <= pressed;
          pending <= 1'b0;
        end else begin
          pending <= 1'b1;
        end
      end else begin
        pending <= 1'b0;
      end
    end
  end
endmodule

>>> src/collision_detect_and_response_core.sv
// Channel  Dir  Payload                   Accept
// item     in   cdr_pkg::item_t           valid & ready
// result   out  cdr_pkg::result_t         valid & ready
// cfg      in   register index and data   valid & ready
// An update request passes through baseline products, baseline update, ratio
// product and spike compare in the current lane, then the merge into the output
// register. A clear request writes the output register straight from the take.
// The next request is taken only once the lanes are idle and the result register
// is empty. Reset is synchronous.
module collision_detect_and_response_core (
  input logic clk,
  input logic rst,
  cdr_if.sink   item,
  cdr_if.source result,
  cdr_if.sink   cfg
);
  import cdr_pkg::*;

  cfg_regs_t regs;
  item_t     cur;
  logic      busy;
  logic      take;
  logic      start;
  logic      clear;
  logic      lane_done;
  lane_hits_t hits;
  logic [17:0] jerk_value;
  logic [15:0] baseline_ma;
  logic      level;
  logic      start_d;
  logic      out_valid;
  result_t   out_reg;
  logic [3:0] flags;
  phase_t    phase;
  logic [31:0] phase_start;
  logic [31:0] collision_total;
  logic [31:0] bumper_total;

  assign cfg.ready = 1'b1;
  assign item.ready = !busy && !out_valid;
  assign take = item.valid && item.ready;
  assign result.valid = out_valid;
  assign result.payload = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{18'd6144, 16'd10, 8'd3, 16'd50, 8'd5, 8'd32, 16'd20, 16'd300};
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.payload.index))
        REG_JERK_THRESHOLD:  regs.jerk_threshold <= cfg.payload.data[17:0];
        REG_JERK_WINDOW:     regs.jerk_window_ms <= cfg.payload.data[15:0];
        REG_JERK_NEEDED:     regs.jerk_samples_needed <= cfg.payload.data[7:0];
        REG_CURRENT_WINDOW:  regs.current_window_ms <= cfg.payload.data[15:0];
        REG_CURRENT_NEEDED:  regs.current_samples_needed <= cfg.payload.data[7:0];
        REG_SPIKE_RATIO:     regs.spike_ratio_q4 <= cfg.payload.data[7:0];
        REG_BUMPER_DEBOUNCE: regs.bumper_debounce_ms <= cfg.payload.data[15:0];
        REG_RESUME_DELAY:    regs.resume_delay_ms <= cfg.payload.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= item.payload;
  end

  assign start = take && item.payload.operation == OP_UPDATE;
  assign clear = take && item.payload.operation == OP_CLEAR;

  cdr_jerk_lane u_jerk (
    .clk, .rst, .start, .clear, .item(item.payload), .cfg(regs),
    .hit(hits.jerk_hit), .jerk_value
  );

  cdr_current_lane u_current (
    .clk, .rst, .start(start_d), .clear, .item(cur), .cfg(regs),
    .hit(hits.current_hit), .done(lane_done), .baseline_ma
  );

  cdr_bumper_lane u_bumper (
    .clk, .rst, .start, .item(item.payload), .cfg(regs), .level
  );

  assign hits.bumper_hit = level;

  // Merge stage: latch the flags, count, and step the response sequence.
  logic [3:0]  fl;
  logic [31:0] ct;
  phase_t      ph;
  logic [31:0] ps;
  logic [31:0] elapsed;
  always_comb begin
    fl = flags;
    ct = collision_total;
    ph = phase;
    ps = phase_start;
    if (hits.jerk_hit) fl[0] = 1'b1;
    if (hits.current_hit) fl[1] = 1'b1;
    if (hits.bumper_hit) fl[2] = 1'b1;
    if (fl[2:0] != 3'b000) begin
      if (!fl[3]) ct = ct + 32'd1;
      fl[3] = 1'b1;
    end
    if (fl[3] && ph == PH_OK) begin
      ph = PH_DETECTED;
      ps = cur.now_ms;
    end
    elapsed = cur.now_ms - ps;
    case (ph)
      PH_DETECTED: begin ph = PH_STOPPED; ps = cur.now_ms; end
      PH_STOPPED: if (elapsed > StopMs) begin ph = PH_RETREAT; ps = cur.now_ms; end
      PH_RETREAT: if (elapsed > RetreatMs) begin ph = PH_TURN; ps = cur.now_ms; end
      PH_TURN: if (elapsed > TurnMs) begin ph = PH_RESUME; ps = cur.now_ms; end
      PH_RESUME:
        if (elapsed > 32'(regs.resume_delay_ms)) begin
          ph = PH_OK;
          ps = cur.now_ms;
          fl = 4'd0;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      start_d <= 1'b0;
      out_valid <= 1'b0;
      flags <= '0;
      phase <= PH_OK;
      phase_start <= '0;
      collision_total <= '0;
      bumper_total <= '0;
    end else begin
      start_d <= start;
      if (result.valid && result.ready) out_valid <= 1'b0;
      if (start) busy <= 1'b1;
      if (clear) begin
        phase <= PH_OK;
        phase_start <= item.payload.now_ms;
        flags <= '0;
        out_valid <= 1'b1;
        out_reg.response_state <= PH_OK;
        out_reg.active <= 1'b0;
        out_reg.jerk_flag <= 1'b0;
        out_reg.current_flag <= 1'b0;
        out_reg.bumper_flag <= 1'b0;
        out_reg.bumper_level <= level;
        out_reg.jerk_sum <= jerk_value;
        out_reg.baseline_ma <= baseline_ma;
        out_reg.collision_count <= collision_total;
        out_reg.bumper_event_count <= bumper_total;
      end else if (lane_done) begin
        busy <= 1'b0;
        flags <= fl;
        phase <= ph;
        phase_start <= ps;
        collision_total <= ct;
        bumper_total <= bumper_total + 32'(level);
        out_valid <= 1'b1;
        out_reg.response_state <= ph;
        out_reg.active <= ph != PH_OK;
        out_reg.jerk_flag <= fl[0];
        out_reg.current_flag <= fl[1];
        out_reg.bumper_flag <= fl[2];
        out_reg.bumper_level <= level;
        out_reg.jerk_sum <= jerk_value;
        out_reg.baseline_ma <= baseline_ma;
        out_reg.collision_count <= ct;
        out_reg.bumper_event_count <= bumper_total + 32'(level);
      end
    end
  end
endmodule

>>> src/cdr_checker.sv
module cdr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input cdr_pkg::result_t out_payload
);
  import cdr_pkg::*;

  a_active: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_payload.active == (out_payload.response_state != PH_OK)))
    else $error("active disagrees with state");

  a_ok_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_payload.response_state == PH_OK && out_payload.active == 1'b0
     && out_payload.jerk_flag) |-> out_payload.collision_count != 32'd0)
    else $error("flag without any collision counted");

  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while result waits");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_payload))
    else $error("result changed under stall");

  // A request in flight closes the input until its result has left.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");
endmodule

bind collision_detect_and_response_core cdr_checker u_cdr_checker (
  .clk(clk), .rst(rst),
  .in_valid(item.valid), .in_ready(item.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .out_payload(result.payload)
);
